// ===== sv/acps_pkg.sv =====
// Package of shared types and constants for the crossing price selector.
`default_nettype none
package acps_pkg;

  localparam int unsigned ValW = 63;

  // Result kinds.
  localparam logic [1:0] KIND_CAND = 2'd0;
  localparam logic [1:0] KIND_BEST = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MIXED    = 3'd1;
  localparam logic [2:0] ERR_FULL     = 3'd2;
  localparam logic [2:0] ERR_NOTIONAL = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Register addresses.
  localparam logic [1:0] REG_NOTIONAL = 2'd0;

  typedef struct packed {
    logic [63:0] instrument_id;
    logic        side;
    logic [62:0] price;
    logic [62:0] quantity;
    logic        last_row;
  } request_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [62:0]        cand_price;
    logic [62:0]        buy_total;
    logic [62:0]        sell_total;
    logic signed [63:0] signed_gap;
    logic [62:0]        abs_gap;
    logic [62:0]        exec_qty;
    logic [2:0]         error_code;
    logic               last_result;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_row;     // store the held row
    logic ins_step;     // one step of the sorted price insert
    logic ins_shift;    // shift price table up at insert point
    logic ins_place;    // write the price into the table
    logic scan_begin;   // clear sums for a new price
    logic scan_row;     // accumulate the current row
    logic next_price;   // advance to the next price
    logic cand_update;  // compare with best
    logic clear_book;   // drop the book
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       ins_found;   // insert position found
    logic       ins_dup;     // price already in table
    logic       ins_room;    // table not full
    logic       ins_done;    // shift reached insert point
    logic       row_last;    // all rows scanned
    logic       price_last;  // scanning the last price
    logic       overflow;    // sum overflow on the current row
  } stat_t;

endpackage : acps_pkg
`default_nettype wire

// ===== sv/acps_notional_chk.sv =====
// Multi-cycle price times quantity limit check by shift and add.
`default_nettype none
module acps_notional_chk (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [62:0] price,
  input  wire logic [62:0] quantity,
  input  wire logic [62:0] limit,
  output logic             done,
  output logic             over
);
  import acps_pkg::*;

  // Product grows one quantity bit per cycle; overflow is kept sticky, limit compared at the end.
  logic [62:0] mcand;
  logic [62:0] mplier;
  logic [63:0] acc;
  logic [5:0]  cnt;
  logic        busy;
  logic        sticky;
  logic [63:0] acc_next;
  logic        ovf_bit;

  always_comb begin
    acc_next = acc;
    ovf_bit  = 1'b0;
    if (mplier[0]) begin
      acc_next = acc + {1'b0, mcand};
    end
    // Shifted multiplicand leaving 63 bits while bits remain means too big.
    if (mcand[62] && (mplier[62:1] != 62'd0)) begin
      ovf_bit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      over <= 1'b0;
      sticky <= 1'b0;
    end else if (go) begin
      busy   <= 1'b1;
      mcand  <= price;
      mplier <= quantity;
      acc    <= 64'd0;
      sticky <= 1'b0;
      cnt    <= 6'd0;
    end else if (busy) begin
      acc    <= acc_next;
      mcand  <= {mcand[61:0], 1'b0};
      mplier <= {1'b0, mplier[62:1]};
      cnt    <= cnt + 6'd1;
      if (ovf_bit || acc_next[63]) begin
        sticky <= 1'b1;
      end
      if (cnt == 6'd62) begin
        busy <= 1'b0;
        done <= 1'b1;
        over <= sticky || ovf_bit || acc_next[63] ||
                (acc_next[62:0] > limit);
      end
    end
  end
endmodule : acps_notional_chk
`default_nettype wire

// ===== sv/acps_datapath.sv =====
// Datapath: row and price stores, scan accumulators, best tracking.
`default_nettype none
module acps_datapath #(
  parameter int unsigned MAX_ROWS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire acps_pkg::request_t req,
  input  wire logic               req_take,
  input  wire acps_pkg::cmd_t     cmd,
  output acps_pkg::stat_t         stat,
  output logic                    rows_full,
  output logic                    inst_mismatch,
  output acps_pkg::request_t      held,
  output acps_pkg::result_t       cand,
  output acps_pkg::result_t       best
);
  import acps_pkg::*;

  localparam int unsigned IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);

  logic [62:0] row_price [MAX_ROWS];
  logic [62:0] row_qty   [MAX_ROWS];
  logic        row_side  [MAX_ROWS];
  logic [62:0] prices    [MAX_ROWS];

  logic [CW-1:0] rows_held;
  logic [CW-1:0] prices_held;
  logic [63:0]   book_inst;
  logic          known;
  logic [CW-1:0] ins_idx;
  logic [CW-1:0] shf_idx;
  logic [CW-1:0] ins_addr;
  logic [CW-1:0] shf_addr;
  logic [CW-1:0] row_idx;
  logic [CW-1:0] pr_idx;
  logic [62:0]   rd_price;
  logic [62:0]   rd_qty;
  logic          rd_side;
  logic [62:0]   rd_cand;
  logic [62:0]   ins_rd;
  logic [62:0]   shf_rd;
  logic [63:0]   buy;
  logic [63:0]   sell;
  logic [62:0]   bp;
  logic [62:0]   bb;
  logic [62:0]   bs;
  logic          bvalid;

  function automatic logic [62:0] absdiff(input logic [62:0] a, input logic [62:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [62:0] minv(input logic [62:0] a, input logic [62:0] b);
    minv = (a < b) ? a : b;
  endfunction

  function automatic logic beats(input logic [62:0] p, input logic [62:0] b,
                                 input logic [62:0] s);
    logic [62:0] ab, ex, bab, bex;
    logic nn, bnn;
    ab = absdiff(b, s); ex = minv(b, s);
    bab = absdiff(bb, bs); bex = minv(bb, bs);
    nn = (b >= s); bnn = (bb >= bs);
    if (ab != bab) beats = ab < bab;
    else if (ex != bex) beats = ex > bex;
    else if (nn != bnn) beats = nn;
    else beats = p < bp;
  endfunction

  function automatic result_t mk(input logic [1:0] k, input logic [62:0] p,
                                 input logic [62:0] b, input logic [62:0] s,
                                 input logic l);
    result_t r;
    r.kind = k; r.cand_price = p; r.buy_total = b; r.sell_total = s;
    r.signed_gap = $signed({1'b0, b}) - $signed({1'b0, s});
    r.abs_gap = absdiff(b, s); r.exec_qty = minv(b, s);
    r.error_code = ERR_NONE; r.last_result = l;
    mk = r;
  endfunction

  // Registered reads of the stores.
  always_ff @(posedge clk) begin
    rd_price <= row_price[row_idx[IW-1:0]];
    rd_qty   <= row_qty[row_idx[IW-1:0]];
    rd_side  <= row_side[row_idx[IW-1:0]];
  end

  // Held request and row writes.
  always_ff @(posedge clk) begin
    if (req_take) begin
      held <= req;
    end
    if (cmd.load_row) begin
      row_price[rows_held[IW-1:0]] <= held.price;
      row_qty[rows_held[IW-1:0]]   <= held.quantity;
      row_side[rows_held[IW-1:0]]  <= held.side;
    end
  end

  // Read addresses follow the pointer values of the next cycle.
  always_comb begin
    ins_addr = ins_idx;
    if (cmd.load_row) begin
      ins_addr = '0;
    end else if (cmd.ins_step) begin
      ins_addr = ins_idx + CW'(1);
    end
    shf_addr = shf_idx;
    if (cmd.load_row) begin
      shf_addr = prices_held;
    end else if (cmd.ins_shift) begin
      shf_addr = shf_idx - CW'(1);
    end
  end

  // Price table: single write port; registered reads at insert, shift - 1 and scan pointers.
  always_ff @(posedge clk) begin
    if (cmd.ins_shift) begin
      prices[shf_idx[IW-1:0]] <= shf_rd;
    end else if (cmd.ins_place) begin
      prices[ins_idx[IW-1:0]] <= held.price;
    end
    ins_rd  <= prices[ins_addr[IW-1:0]];
    shf_rd  <= prices[shf_addr[IW-1:0] - IW'(1)];
    rd_cand <= prices[pr_idx[IW-1:0]];
  end

  assign rows_full     = (rows_held == CW'(MAX_ROWS));
  assign inst_mismatch = known && (book_inst != held.instrument_id);

  always_comb begin
    stat = '0;
    stat.ins_found  = (ins_idx == prices_held) || (ins_rd >= held.price);
    stat.ins_dup    = (ins_idx != prices_held) && (ins_rd == held.price);
    stat.ins_room   = (prices_held != CW'(MAX_ROWS));
    stat.ins_done   = (shf_idx == ins_idx);
    stat.row_last   = (row_idx == rows_held);
    stat.price_last = (pr_idx + CW'(1) == prices_held);
    stat.overflow   = (!rd_side && (rd_price >= rd_cand) &&
                       (((buy + {1'b0, rd_qty}) >> 63) != 64'd0)) ||
                      (rd_side && (rd_price <= rd_cand) &&
                       (((sell + {1'b0, rd_qty}) >> 63) != 64'd0));
  end

  // Book bookkeeping and scanning.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_book) begin
      rows_held   <= '0;
      prices_held <= '0;
      known       <= 1'b0;
      book_inst   <= 64'd0;
      bvalid      <= 1'b0;
      bp <= '0; bb <= '0; bs <= '0;
      ins_idx <= '0; shf_idx <= '0; row_idx <= '0; pr_idx <= '0;
    end else begin
      if (cmd.load_row) begin
        rows_held <= rows_held + CW'(1);
        known     <= 1'b1;
        book_inst <= held.instrument_id;
        ins_idx   <= '0;
        shf_idx   <= prices_held;
      end
      if (cmd.ins_step) begin
        ins_idx <= ins_idx + CW'(1);
      end
      if (cmd.ins_shift) begin
        shf_idx <= shf_idx - CW'(1);
      end
      if (cmd.ins_place) begin
        prices_held <= prices_held + CW'(1);
      end
      if (cmd.scan_begin) begin
        buy <= '0; sell <= '0; row_idx <= '0;
      end
      if (cmd.scan_row) begin
        row_idx <= row_idx + CW'(1);
        if (!rd_side && rd_price >= rd_cand) begin
          buy <= buy + {1'b0, rd_qty};
        end else if (rd_side && rd_price <= rd_cand) begin
          sell <= sell + {1'b0, rd_qty};
        end
      end
      if (cmd.next_price) begin
        pr_idx <= pr_idx + CW'(1);
      end
      if (cmd.cand_update) begin
        if (!bvalid || beats(rd_cand, buy[62:0], sell[62:0])) begin
          bp <= rd_cand; bb <= buy[62:0]; bs <= sell[62:0];
          bvalid <= 1'b1;
        end
      end
    end
  end

  // Row address for the next registered read.
  logic [CW-1:0] row_rd_sel;
  assign row_rd_sel = row_idx;

  always_comb begin
    cand = mk(KIND_CAND, rd_cand, buy[62:0], sell[62:0], 1'b0);
    best = mk(KIND_BEST, bp, bb, bs, 1'b1);
    if (row_rd_sel == '0) begin
      cand.error_code = ERR_NONE;
    end
  end
endmodule : acps_datapath
`default_nettype wire

// ===== sv/acps_ctrl.sv =====
// Controller state machine sequencing checks, insert and scan.
`default_nettype none
module acps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               chk_done,
  input  wire logic               chk_over,
  input  wire logic               rows_full,
  input  wire logic               inst_mismatch,
  input  wire logic               last_row,
  input  wire acps_pkg::stat_t    stat,
  input  wire acps_pkg::result_t  cand,
  input  wire acps_pkg::result_t  best,
  output acps_pkg::cmd_t          cmd,
  output logic                    busy,
  output logic                    req_take,
  output logic                    chk_go,
  output logic                    valid,
  output acps_pkg::result_t       result
);
  import acps_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_FIND  = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_SBEG  = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SROW  = 4'd7;
  localparam logic [3:0] S_CAND  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_BEST  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       emit_err;
  logic [2:0] err_code;
  result_t    err_res;

  assign busy     = (state != S_IDLE);
  assign req_take = start && !busy;
  assign chk_go   = req_take;

  always_comb begin
    state_next = state;
    cmd        = '0;
    emit_err   = 1'b0;
    err_code   = ERR_NONE;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (chk_done) begin
          if (rows_full) begin
            emit_err = 1'b1; err_code = ERR_FULL;
          end else if (chk_over) begin
            emit_err = 1'b1; err_code = ERR_NOTIONAL;
          end else if (inst_mismatch) begin
            emit_err = 1'b1; err_code = ERR_MIXED;
          end else begin
            state_next = S_LOAD;
          end
          if (emit_err) begin
            cmd.clear_book = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        cmd.load_row = 1'b1;
        state_next = S_FIND;
      end
      S_FIND: begin
        if (stat.ins_found) begin
          if (stat.ins_dup || !stat.ins_room) begin
            state_next = last_row ? S_SBEG : S_IDLE;
          end else begin
            state_next = S_SHIFT;
          end
        end else begin
          cmd.ins_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.ins_done) begin
          cmd.ins_place = 1'b1;
          state_next = last_row ? S_SBEG : S_IDLE;
        end else begin
          cmd.ins_shift = 1'b1;
        end
      end
      S_SBEG: begin
        cmd.scan_begin = 1'b1;
        state_next = S_SRD;
      end
      S_SRD: begin
        // Read latency of the row store.
        state_next = S_SROW;
      end
      S_SROW: begin
        if (stat.row_last) begin
          state_next = S_CAND;
        end else begin
          cmd.scan_row = 1'b1;
          if (stat.overflow) begin
            emit_err = 1'b1; err_code = ERR_OVERFLOW;
            cmd.clear_book = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_SRD;
          end
        end
      end
      S_CAND: begin
        cmd.cand_update = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.price_last) begin
          state_next = S_BEST;
        end else begin
          cmd.next_price = 1'b1;
          state_next = S_SBEG;
        end
      end
      S_BEST: begin
        cmd.clear_book = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= emit_err || (state == S_CAND) || (state == S_BEST);
    end
  end

  // Error result: value fields all zero.
  always_comb begin
    err_res             = '0;
    err_res.kind        = KIND_ERR;
    err_res.error_code  = err_code;
    err_res.last_result = 1'b1;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit_err) begin
      result <= err_res;
    end else if (state == S_CAND) begin
      result <= cand;
    end else if (state == S_BEST) begin
      result <= best;
    end
  end
endmodule : acps_ctrl
`default_nettype wire

// ===== sv/auction_crossing_price_select.sv =====
// Top level of the call auction crossing price selector.
// A row passes through a serial notional check, a load step and a sorted price insert
// whose length is set by the insert point and the table size. The last row then scans
// every row for each distinct price and emits a candidate, then the best result.
// One request at a time while busy is high; results are strobed by valid for one cycle,
// no stall. Reset clears book, limit to max.
`default_nettype none
module auction_crossing_price_select #(
  parameter int unsigned MAX_ROWS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire acps_pkg::request_t request,
  output logic                    valid,
  output acps_pkg::result_t       result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  import acps_pkg::*;

  logic [62:0] limit;
  cmd_t        cmd;
  stat_t       stat;
  logic        rows_full, inst_mismatch;
  request_t    held;
  result_t     cand, best;
  logic        req_take, chk_go, chk_done, chk_over;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= {63{1'b1}};
    end else if (psel && penable && pwrite && paddr == REG_NOTIONAL) begin
      limit <= pwdata[62:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == REG_NOTIONAL) begin
      prdata = {1'b0, limit};
    end
  end

  acps_notional_chk u_chk (
    .clk, .rst, .go(chk_go), .price(request.price), .quantity(request.quantity),
    .limit, .done(chk_done), .over(chk_over)
  );

  acps_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk, .rst, .req(request), .req_take, .cmd, .stat, .rows_full,
    .inst_mismatch, .held, .cand, .best
  );

  acps_ctrl u_ctrl (
    .clk, .rst, .start, .chk_done, .chk_over, .rows_full, .inst_mismatch,
    .last_row(held.last_row), .stat, .cand,
    .best, .cmd, .busy, .req_take, .chk_go, .valid, .result
  );
endmodule : auction_crossing_price_select
`default_nettype wire
